>>> hdl/sha_pkg.sv
// shared types and constants for the sha-256 hash core
`default_nettype none
package sha_pkg;

  // sequencer states
  typedef enum logic [2:0] {
    S_IDLE,
    S_PAD,
    S_LEN,
    S_INIT,
    S_ROUND,
    S_ADD,
    S_EMIT
  } sha_state_t;

  // commands from the sequencer to the datapath
  typedef struct packed {
    logic       wr_byte;
    logic [7:0] wr_data;
    logic       cnt_msg;
    logic       wr_len;
    logic       init_vars;
    logic       do_round;
    logic [5:0] round;
    logic       add_hash;
    logic       clear_msg;
    logic [2:0] emit_idx;
  } sha_cmd_t;

  // status from the datapath to the sequencer
  typedef struct packed {
    logic [5:0] fill_pos;
  } sha_sts_t;

  localparam logic [7:0] PAD_MARK     = 8'h80;
  localparam logic [7:0] PAD_ZERO     = 8'h00;
  localparam logic [5:0] POS_LAST     = 6'd63;
  localparam logic [5:0] POS_PRE_LEN  = 6'd55;
  localparam logic [5:0] POS_LEN      = 6'd56;
  localparam logic [5:0] ROUND_LAST   = 6'd63;
  localparam logic [2:0] WORD_LAST    = 3'd7;

  localparam logic [31:0] SHA_H0 [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  localparam logic [31:0] SHA_K [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

endpackage
`default_nettype wire

>>> hdl/sha256_hash_core.sv
// sha-256 hash core top level: sequencer plus datapath
// message words are taken only while idle; each full 64-byte block is then compressed:
//   load working variables, 64 rounds at one round per cycle, hash add
// end of message: pad bytes written one at a time, then the length, then each final block
// digest: eight output words, one per cycle when out_stall is low
// pace is set by the single round unit; input stalls while a block is compressed
// reset: hash set to initial values, counters and sequencer cleared; buffer not cleared
`default_nettype none
module sha256_hash_core
  import sha_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [7:0]  msg_byte,
  input  wire logic        byte_present,
  input  wire logic        end_of_message,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [31:0]      digest_word,
  output logic [2:0]       word_index,
  output logic             last_word
);

  sha_cmd_t cmd;
  sha_sts_t sts;

  // sequencer: takes words only while idle, walks padding and rounds
  sha_ctrl u_ctrl (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .msg_byte       (msg_byte),
    .byte_present   (byte_present),
    .end_of_message (end_of_message),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .sts            (sts),
    .cmd            (cmd)
  );

  // datapath: block buffer, schedule, rounds and running hash
  sha_dp u_dp (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .sts         (sts),
    .digest_word (digest_word)
  );

  // digest words come straight from the hash registers, held while stalled
  assign word_index = cmd.emit_idx;
  assign last_word  = (cmd.emit_idx == WORD_LAST);

endmodule
`default_nettype wire

>>> hdl/sha_dp.sv
// sha-256 datapath: block buffer, message schedule, round logic, hash state
`default_nettype none
module sha_dp
  import sha_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire sha_cmd_t    cmd,
  output sha_sts_t         sts,
  output logic [31:0]      digest_word
);

  logic [31:0] hash [8];
  logic [31:0] vars [8];
  logic [31:0] win  [16];
  logic [63:0] byte_count;
  logic [5:0]  fill_pos;

  logic [31:0] w_next;
  logic [31:0] t1;
  logic [31:0] t2;
  logic [63:0] bit_len;

  function automatic logic [31:0] ror(input logic [31:0] v, input int s);
    ror = (v >> s) | (v << (32 - s));
  endfunction

  always_comb begin
    w_next = win[0]
           + (ror(win[1], 7) ^ ror(win[1], 18) ^ (win[1] >> 3))
           + win[9]
           + (ror(win[14], 17) ^ ror(win[14], 19) ^ (win[14] >> 10));
    t1 = vars[7]
       + (ror(vars[4], 6) ^ ror(vars[4], 11) ^ ror(vars[4], 25))
       + ((vars[4] & vars[5]) ^ (~vars[4] & vars[6]))
       + SHA_K[cmd.round]
       + win[0];
    t2 = (ror(vars[0], 2) ^ ror(vars[0], 13) ^ ror(vars[0], 22))
       + ((vars[0] & vars[1]) ^ (vars[0] & vars[2]) ^ (vars[1] & vars[2]));
    bit_len = {byte_count[60:0], 3'b000};
  end

  // hash state and counters
  always_ff @(posedge clk) begin
    if (rst || cmd.clear_msg) begin
      for (int i = 0; i < 8; i++) hash[i] <= SHA_H0[i];
      byte_count <= '0;
      fill_pos   <= '0;
    end else begin
      if (cmd.add_hash) begin
        for (int i = 0; i < 8; i++) hash[i] <= hash[i] + vars[i];
      end
      if (cmd.wr_byte) fill_pos <= fill_pos + 6'd1;
      if (cmd.cnt_msg) byte_count <= byte_count + 64'd1;
    end
  end

  // block buffer doubles as the rolling schedule window
  always_ff @(posedge clk) begin
    if (cmd.wr_byte) begin
      win[fill_pos[5:2]][{~fill_pos[1:0], 3'b000} +: 8] <= cmd.wr_data;
    end else if (cmd.wr_len) begin
      win[14] <= bit_len[63:32];
      win[15] <= bit_len[31:0];
    end else if (cmd.do_round) begin
      for (int i = 0; i < 15; i++) win[i] <= win[i + 1];
      win[15] <= w_next;
    end
  end

  // working variables a..h
  always_ff @(posedge clk) begin
    if (cmd.init_vars) begin
      for (int i = 0; i < 8; i++) vars[i] <= hash[i];
    end else if (cmd.do_round) begin
      vars[7] <= vars[6];
      vars[6] <= vars[5];
      vars[5] <= vars[4];
      vars[4] <= vars[3] + t1;
      vars[3] <= vars[2];
      vars[2] <= vars[1];
      vars[1] <= vars[0];
      vars[0] <= t1 + t2;
    end
  end

  assign sts.fill_pos = fill_pos;
  assign digest_word  = hash[cmd.emit_idx];

endmodule
`default_nettype wire

>>> hdl/sha_ctrl.sv
// sha-256 sequencer: byte intake, padding, round count and digest output
`default_nettype none
module sha_ctrl
  import sha_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       in_valid,
  output logic            in_stall,
  input  wire logic [7:0] msg_byte,
  input  wire logic       byte_present,
  input  wire logic       end_of_message,
  output logic            out_valid,
  input  wire logic       out_stall,
  input  wire sha_sts_t   sts,
  output sha_cmd_t        cmd
);

  sha_state_t state, state_next;
  logic [5:0] round, round_next;
  logic [2:0] emit_idx, emit_idx_next;
  logic       pad_active, pad_active_next;
  logic       mark_done, mark_done_next;
  logic       final_blk, final_blk_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      round      <= '0;
      emit_idx   <= '0;
      pad_active <= 1'b0;
      mark_done  <= 1'b0;
      final_blk  <= 1'b0;
    end else begin
      state      <= state_next;
      round      <= round_next;
      emit_idx   <= emit_idx_next;
      pad_active <= pad_active_next;
      mark_done  <= mark_done_next;
      final_blk  <= final_blk_next;
    end
  end

  always_comb begin
    state_next      = state;
    round_next      = round;
    emit_idx_next   = emit_idx;
    pad_active_next = pad_active;
    mark_done_next  = mark_done;
    final_blk_next  = final_blk;
    cmd             = '0;
    cmd.round       = round;
    cmd.emit_idx    = emit_idx;
    in_stall        = 1'b1;
    out_valid       = 1'b0;

    unique case (state)
      S_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd.wr_byte = byte_present;
          cmd.cnt_msg = byte_present;
          cmd.wr_data = msg_byte;
          if (end_of_message) pad_active_next = 1'b1;
          if (byte_present && sts.fill_pos == POS_LAST) begin
            state_next = S_INIT;
          end else if (end_of_message) begin
            state_next = S_PAD;
          end
        end
      end
      S_PAD: begin
        cmd.wr_byte    = 1'b1;
        cmd.wr_data    = mark_done ? PAD_ZERO : PAD_MARK;
        mark_done_next = 1'b1;
        if (sts.fill_pos == POS_LAST) begin
          state_next = S_INIT;
        end else if (sts.fill_pos == POS_PRE_LEN) begin
          state_next = S_LEN;
        end
      end
      S_LEN: begin
        cmd.wr_len     = 1'b1;
        final_blk_next = 1'b1;
        state_next     = S_INIT;
      end
      S_INIT: begin
        cmd.init_vars = 1'b1;
        round_next    = '0;
        state_next    = S_ROUND;
      end
      S_ROUND: begin
        cmd.do_round = 1'b1;
        round_next   = round + 6'd1;
        if (round == ROUND_LAST) state_next = S_ADD;
      end
      S_ADD: begin
        cmd.add_hash = 1'b1;
        if (final_blk) begin
          emit_idx_next = '0;
          state_next    = S_EMIT;
        end else if (pad_active) begin
          state_next = S_PAD;
        end else begin
          state_next = S_IDLE;
        end
      end
      S_EMIT: begin
        out_valid = 1'b1;
        if (!out_stall) begin
          emit_idx_next = emit_idx + 3'd1;
          if (emit_idx == WORD_LAST) begin
            cmd.clear_msg   = 1'b1;
            pad_active_next = 1'b0;
            mark_done_next  = 1'b0;
            final_blk_next  = 1'b0;
            state_next      = S_IDLE;
          end
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

`ifndef SYNTHESIS
  a_round_end: assert property (@(posedge clk) disable iff (rst)
    (state == S_ROUND && round == ROUND_LAST) |=> state == S_ADD)
    else $error("compression did not end after the last round");

  a_emit_end: assert property (@(posedge clk) disable iff (rst)
    (state == S_EMIT && !out_stall && emit_idx == WORD_LAST) |=>
    (state == S_IDLE && !pad_active && !final_blk))
    else $error("digest output did not return to idle");

  a_one_cmd: assert property (@(posedge clk) disable iff (rst)
    $onehot0({cmd.wr_byte, cmd.wr_len, cmd.init_vars, cmd.do_round, cmd.add_hash}))
    else $error("conflicting datapath commands");

  a_len_pos: assert property (@(posedge clk) disable iff (rst)
    state == S_LEN |-> sts.fill_pos == POS_LEN)
    else $error("length written at wrong block position");
`endif

endmodule
`default_nettype wire

>>> sim/sha_digest_checker.sv
// channel monitor with sha-256 digest predictor and word-by-word compare
`default_nettype none
module sha_digest_checker (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  input  wire logic        in_stall,
  input  wire logic [7:0]  msg_byte,
  input  wire logic        byte_present,
  input  wire logic        end_of_message,
  input  wire logic        out_valid,
  input  wire logic        out_stall,
  input  wire logic [31:0] digest_word,
  input  wire logic [2:0]  word_index,
  input  wire logic        last_word,
  output int               fail_count,
  output int               pending
);

  localparam logic [5:0] LEN_POS   = 6'd56;
  localparam logic [5:0] BLOCK_END = 6'd63;
  localparam logic [7:0] MARK_BYTE = 8'h80;

  localparam logic [255:0] IV_WORDS = {
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  localparam logic [64*32-1:0] ROUND_K = {
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  typedef struct {
    logic [31:0] value;
    logic [2:0]  index;
    logic        last;
  } digest_entry_t;

  logic [31:0]   chain [8];
  logic [31:0]   blk_words [16];
  logic [63:0]   msg_len;
  digest_entry_t digest_due [$];

  initial begin
    fail_count = 0;
    pending    = 0;
  end

  function automatic logic [31:0] rotr(input logic [31:0] v, input int s);
    return (v >> s) | (v << (32 - s));
  endfunction

  task automatic start_message();
    int i;
    for (i = 0; i < 8; i++) chain[i] = IV_WORDS[(7 - i) * 32 +: 32];
    for (i = 0; i < 16; i++) blk_words[i] = '0;
    msg_len = '0;
  endtask

  task automatic run_rounds();
    logic [31:0] w [64];
    logic [31:0] a, b, c, d, e, f, g, h, t1, t2;
    int i;
    for (i = 0; i < 16; i++) w[i] = blk_words[i];
    for (i = 16; i < 64; i++) begin
      w[i] = w[i-16] + w[i-7]
           + (rotr(w[i-15], 7) ^ rotr(w[i-15], 18) ^ (w[i-15] >> 3))
           + (rotr(w[i-2], 17) ^ rotr(w[i-2], 19) ^ (w[i-2] >> 10));
    end
    {a, b, c, d, e, f, g, h} = {chain[0], chain[1], chain[2], chain[3],
                                chain[4], chain[5], chain[6], chain[7]};
    for (i = 0; i < 64; i++) begin
      t1 = h + (rotr(e, 6) ^ rotr(e, 11) ^ rotr(e, 25)) + ((e & f) ^ (~e & g))
         + ROUND_K[(63 - i) * 32 +: 32] + w[i];
      t2 = (rotr(a, 2) ^ rotr(a, 13) ^ rotr(a, 22)) + ((a & b) ^ (a & c) ^ (b & c));
      h = g; g = f; f = e; e = d + t1;
      d = c; c = b; b = a; a = t1 + t2;
    end
    chain[0] += a; chain[1] += b; chain[2] += c; chain[3] += d;
    chain[4] += e; chain[5] += f; chain[6] += g; chain[7] += h;
  endtask

  // big-endian packing, compress once the block is full
  task automatic absorb_byte(input logic [5:0] pos, input logic [7:0] b);
    logic [3:0] wi;
    wi = pos[5:2];
    if (pos[1:0] == 2'd0) blk_words[wi] = '0;
    blk_words[wi][8 * (3 - pos[1:0]) +: 8] = b;
    if (pos == BLOCK_END) run_rounds();
  endtask

  task automatic close_message();
    logic [5:0]  pos;
    logic [63:0] bit_len;
    digest_entry_t ent;
    int i;
    pos = msg_len[5:0];
    absorb_byte(pos, MARK_BYTE);
    pos = pos + 6'd1;
    // no room for the length: zero-fill and run an extra block
    if (pos > LEN_POS) begin
      while (pos != 6'd0) begin
        absorb_byte(pos, 8'h00);
        pos = pos + 6'd1;
      end
    end
    while (pos < LEN_POS) begin
      absorb_byte(pos, 8'h00);
      pos = pos + 6'd1;
    end
    bit_len = msg_len << 3;
    blk_words[14] = bit_len[63:32];
    blk_words[15] = bit_len[31:0];
    run_rounds();
    for (i = 0; i < 8; i++) begin
      ent.value = chain[i];
      ent.index = 3'(i);
      ent.last  = (i == 7);
      digest_due.push_back(ent);
    end
    start_message();
  endtask

  task automatic flag_mismatch(input string what);
    $display("%0t checker: %s", $time, what);
    fail_count++;
  endtask

  always @(posedge clk) begin : watch
    digest_entry_t due;
    if (rst) begin
      start_message();
      digest_due.delete();
    end else begin
      if (in_valid && !in_stall) begin
        if (byte_present) begin
          absorb_byte(msg_len[5:0], msg_byte);
          msg_len = msg_len + 64'd1;
        end
        if (end_of_message) close_message();
      end
      if (out_valid && !out_stall) begin
        if (digest_due.size() == 0) begin
          flag_mismatch($sformatf("unexpected digest word %h index %0d",
                                  digest_word, word_index));
        end else begin
          due = digest_due.pop_front();
          if (digest_word !== due.value)
            flag_mismatch($sformatf("word %0d value %h, want %h",
                                    due.index, digest_word, due.value));
          if (word_index !== due.index)
            flag_mismatch($sformatf("word index %0d, want %0d", word_index, due.index));
          if (last_word !== due.last)
            flag_mismatch($sformatf("word %0d last flag %b, want %b",
                                    due.index, last_word, due.last));
        end
      end
    end
    pending = digest_due.size();
  end

endmodule
`default_nettype wire

>>> sim/tb.sv
// stimulus top for the sha-256 hash core: messages in, verdict out
`default_nettype none
module tb;

  // stop when about this many message words have gone in
  localparam int ITEM_GOAL    = 430;
  // receiver hold-off starts once this many words were sent
  localparam int HOLD_AT      = 180;
  localparam int HOLD_CYCLES  = 700;
  // quiet after the last digest: a final block plus slack
  localparam int DRAIN_CYCLES = 300;
  localparam int CYCLE_LIMIT  = 400000;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [7:0]  msg_byte = 8'h00;
  logic        byte_present = 1'b0;
  logic        end_of_message = 1'b0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [31:0] digest_word;
  logic [2:0]  word_index;
  logic        last_word;

  int fail_count;
  int pending;
  int words_sent = 0;
  int cycles = 0;
  int msg_num;
  // set while both sides run flat out, no random gaps
  bit calm = 1'b0;

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  sha256_hash_core dut (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .msg_byte       (msg_byte),
    .byte_present   (byte_present),
    .end_of_message (end_of_message),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .digest_word    (digest_word),
    .word_index     (word_index),
    .last_word      (last_word)
  );

  sha_digest_checker u_checker (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .msg_byte       (msg_byte),
    .byte_present   (byte_present),
    .end_of_message (end_of_message),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .digest_word    (digest_word),
    .word_index     (word_index),
    .last_word      (last_word),
    .fail_count     (fail_count),
    .pending        (pending)
  );

  // offer one word, with a random gap first unless calm; returns once accepted
  task automatic send_word(input logic [7:0] b, input logic p, input logic e);
    while (!calm && $urandom_range(99) < 34) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid       <= 1'b1;
    msg_byte       <= b;
    byte_present   <= p;
    end_of_message <= e;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    // words with no byte and no end are dropped by the core, not counted
    if (p || e) words_sent++;
  endtask

  // one message of len bytes; the end rides on the last byte or on an empty word
  task automatic send_message(input int len, input bit end_on_byte);
    int k;
    for (k = 0; k < len; k++) begin
      // stray no-op words sprinkled into the stream
      if (!calm && $urandom_range(15) == 0) send_word(8'($urandom_range(255)), 1'b0, 1'b0);
      send_word(8'($urandom_range(255)), 1'b1, end_on_byte && (k == len - 1));
    end
    if (!(end_on_byte && len > 0)) send_word(8'($urandom_range(255)), 1'b0, 1'b1);
  endtask

  // mostly short messages, with lengths clustered around the padding edges:
  // 55/56 decide one or two final blocks, 63/64 a full block before the pad
  function automatic int pick_len();
    case ($urandom_range(9)) inside
      [0:4]:   return $urandom_range(8);
      5:       return $urandom_range(40, 9);
      6:       return $urandom_range(57, 54);
      7:       return $urandom_range(65, 62);
      8:       return $urandom_range(121, 118);
      default: return $urandom_range(2);
    endcase
  endfunction

  // receiver: random stalls, a calm stretch, and one long hold-off so the
  // core backs up with a finished digest and stalls its input
  initial begin : receiver
    bit held;
    held = 1'b0;
    forever begin
      @(posedge clk);
      if (!held && words_sent >= HOLD_AT) begin
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        held = 1'b1;
      end else begin
        out_stall <= !calm && ($urandom_range(99) < 34);
      end
    end
  end

  // watchdog
  initial begin
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("tb NOT OK");
    $finish;
  end

  initial begin
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // empty message, end on a word with no byte
    send_word(8'ha5, 1'b0, 1'b1);
    // no-op word, then empty again: digest must match and state must be fresh
    send_word(8'hff, 1'b0, 1'b0);
    send_word(8'h00, 1'b0, 1'b1);
    // single byte carrying the end, both byte extremes
    send_word(8'h00, 1'b1, 1'b1);
    send_word(8'hff, 1'b1, 1'b1);
    // "abc" with the end on the last byte
    send_word(8'h61, 1'b1, 1'b0);
    send_word(8'h62, 1'b1, 1'b0);
    send_word(8'h63, 1'b1, 1'b1);
    // "abc" with a no-op in the middle and the end on an empty word
    send_word(8'h61, 1'b1, 1'b0);
    send_word(8'h62, 1'b1, 1'b0);
    send_word(8'h5a, 1'b0, 1'b0);
    send_word(8'h63, 1'b1, 1'b0);
    send_word(8'h00, 1'b0, 1'b1);

    // random messages; a few in the middle run with no gaps on either side
    msg_num = 0;
    while (words_sent < ITEM_GOAL) begin
      calm = (msg_num >= 4 && msg_num < 10);
      send_message(pick_len(), 1'($urandom_range(1)));
      msg_num++;
    end
    calm = 1'b0;
    in_valid <= 1'b0;

    // let the checker see the last word, then wait out every digest
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (fail_count == 0) begin
      $display("tb OK");
    end else begin
      $display("tb NOT OK");
    end
    $finish;
  end

endmodule
`default_nettype wire
